/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the grid distance fill RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GBF_ASSERT_IMP(lbl, ante, cons, msg)
`define GBF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/gbf_pkg.sv */
// Types and constants shared by the grid distance fill modules.
package gbf_pkg;

  localparam int MAX_SIDE = 16;
  localparam int ROW_W    = 4;
  localparam int CELL_AW  = 2 * ROW_W;
  localparam int DIST_W   = 9;
  localparam int SIDE_W   = 5;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_GRID_SIDE = 2'd0;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             cell_open;
  } gbf_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reached;
  } gbf_out_t;

  typedef struct packed {
    logic               open_we;
    logic               dist_we;
    logic [CELL_AW-1:0] wr_addr;
    logic               open_wdata;
    logic [DIST_W-1:0]  dist_wdata;
    logic [CELL_AW-1:0] rd_addr;
  } gbf_mem_req_t;

endpackage

/* hw/rtl/gbf_store.sv */
// Open map and distance memories: one write and one registered read each.
module gbf_store (
  input  logic                 clk,
  input  gbf_pkg::gbf_mem_req_t req,
  output logic                 rd_open,
  output logic [gbf_pkg::DIST_W-1:0] rd_dist
);
  import gbf_pkg::*;

  localparam int CELLS = MAX_SIDE * MAX_SIDE;

  logic              open_mem [CELLS];
  logic [DIST_W-1:0] dist_mem [CELLS];
  logic              rd_open_r;
  logic [DIST_W-1:0] rd_dist_r;

  always_ff @(posedge clk) begin
    if (req.open_we) begin
      open_mem[req.wr_addr] <= req.open_wdata;
    end
    rd_open_r <= open_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.dist_we) begin
      dist_mem[req.wr_addr] <= req.dist_wdata;
    end
    rd_dist_r <= dist_mem[req.rd_addr];
  end

  assign rd_open = rd_open_r;
  assign rd_dist = rd_dist_r;

endmodule

/* hw/rtl/gbf_seq.sv */
// Sequencer: load/read handling and the level-by-level wavefront scan.
module gbf_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  gbf_pkg::gbf_in_t            in_item,
  input  logic [gbf_pkg::SIDE_W-1:0]  side,
  input  logic                        rd_open,
  input  logic [gbf_pkg::DIST_W-1:0]  rd_dist,
  output logic                        busy,
  output gbf_pkg::gbf_mem_req_t       mem_req,
  output logic                        out_valid,
  output gbf_pkg::gbf_out_t           out_item
);
  import gbf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_CEN, S_CHK, S_NBC} state_t;

  localparam logic [1:0] NB_DOWN  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_UP    = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [DIST_W-1:0] x_r, x_nxt;
  logic              added_r, added_nxt;
  logic [1:0]        nb_r, nb_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_oob_r, rd_oob_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbf_out_t          out_item_r, out_item_nxt;

  logic [2*SIDE_W-1:0] side_sq;
  logic [DIST_W-1:0]   none;
  logic [SIDE_W-1:0]   side_m1;
  logic [ROW_W-1:0]    last_idx;
  logic                cell_last;
  logic [DIST_W-1:0]   cmp_ref;
  logic                cmp_eq;
  logic                hit;
  logic                cell_done;
  logic                more;
  logic [ROW_W-1:0]    r_adv, c_adv;

  function automatic logic [CELL_AW-1:0] nb_addr(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] c,
                                                 input logic [1:0] nb);
    logic [ROW_W-1:0] rr, cc;
    rr = r;
    cc = c;
    case (nb)
      NB_DOWN:  rr = r + 1'b1;
      NB_RIGHT: cc = c + 1'b1;
      NB_UP:    rr = r - 1'b1;
      NB_LEFT:  cc = c - 1'b1;
      default:  rr = r;
    endcase
    return {rr, cc};
  endfunction

  function automatic logic nb_ok(input logic [ROW_W-1:0] r,
                                 input logic [ROW_W-1:0] c,
                                 input logic [1:0] nb,
                                 input logic [SIDE_W-1:0] sd);
    logic ok;
    case (nb)
      NB_DOWN:  ok = ({1'b0, r} + SIDE_W'(1)) < sd;
      NB_RIGHT: ok = ({1'b0, c} + SIDE_W'(1)) < sd;
      NB_UP:    ok = (r != '0);
      NB_LEFT:  ok = (c != '0);
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign side_sq   = side * side;
  assign none      = side_sq[DIST_W-1:0];
  assign side_m1   = side - SIDE_W'(1);
  assign last_idx  = side_m1[ROW_W-1:0];
  assign cell_last = (r_r == last_idx) && (c_r == last_idx);
  assign r_adv     = (c_r == last_idx) ? r_r + 1'b1 : r_r;
  assign c_adv     = (c_r == last_idx) ? '0 : c_r + 1'b1;

  // Shared compare: against the level in the neighbor scan, else against "unreached".
  assign cmp_ref = (state_r == S_NBC) ? x_r : none;
  assign cmp_eq  = (rd_dist == cmp_ref);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    x_nxt         = x_r;
    added_nxt     = added_r;
    nb_nxt        = nb_r;
    rd_pend_nxt   = 1'b0;
    rd_oob_nxt    = rd_oob_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req       = '0;
    mem_req.rd_addr = {in_item.row, in_item.col};
    mem_req.wr_addr = {r_r, c_r};
    hit       = 1'b0;
    cell_done = 1'b0;
    more      = 1'b0;

    // Second half of a read item: data is back from the store.
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      if (rd_oob_r) begin
        out_item_nxt.distance = none;
        out_item_nxt.reached  = 1'b0;
      end else begin
        out_item_nxt.distance = rd_dist;
        out_item_nxt.reached  = (rd_dist < none);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.opcode)
            OP_LOAD: begin
              mem_req.open_we    = 1'b1;
              mem_req.wr_addr    = {in_item.row, in_item.col};
              mem_req.open_wdata = in_item.cell_open;
            end
            OP_SOLVE: begin
              state_nxt = S_CLR;
              r_nxt     = '0;
              c_nxt     = '0;
            end
            OP_READ: begin
              rd_pend_nxt = 1'b1;
              rd_oob_nxt  = ({1'b0, in_item.row} >= side) || ({1'b0, in_item.col} >= side);
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLR: begin
        mem_req.dist_we    = 1'b1;
        mem_req.dist_wdata = ((r_r == '0) && (c_r == '0)) ? '0 : none;
        if (cell_last) begin
          state_nxt = S_CEN;
          r_nxt     = '0;
          c_nxt     = '0;
          x_nxt     = '0;
          added_nxt = 1'b0;
        end else begin
          r_nxt = r_adv;
          c_nxt = c_adv;
        end
      end
      S_CEN: begin
        mem_req.rd_addr = {r_r, c_r};
        state_nxt       = S_CHK;
      end
      S_CHK: begin
        // Skip walls and cells that already hold a level.
        if (!rd_open || !cmp_eq) begin
          cell_done = 1'b1;
        end else begin
          mem_req.rd_addr = nb_addr(r_r, c_r, NB_DOWN);
          nb_nxt          = NB_DOWN;
          state_nxt       = S_NBC;
        end
      end
      S_NBC: begin
        hit = cmp_eq && nb_ok(r_r, c_r, nb_r, side);
        if (hit) begin
          mem_req.dist_we    = 1'b1;
          mem_req.dist_wdata = x_r + 1'b1;
          added_nxt          = 1'b1;
        end
        if (hit || (nb_r == NB_LEFT)) begin
          cell_done = 1'b1;
        end else begin
          nb_nxt          = nb_r + 1'b1;
          mem_req.rd_addr = nb_addr(r_r, c_r, nb_r + 1'b1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cell_done) begin
      if (cell_last) begin
        more = (added_r || hit) && (({1'b0, x_r} + 10'd1) < {1'b0, none});
        if (more) begin
          x_nxt     = x_r + 1'b1;
          added_nxt = 1'b0;
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_CEN;
        end else begin
          state_nxt             = S_IDLE;
          out_valid_nxt         = 1'b1;
          out_item_nxt.distance = x_r;
          out_item_nxt.reached  = 1'b1;
        end
      end else begin
        r_nxt           = r_adv;
        c_nxt           = c_adv;
        mem_req.rd_addr = {r_adv, c_adv};
        state_nxt       = S_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      added_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      added_r     <= added_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    nb_r       <= nb_nxt;
    rd_oob_r   <= rd_oob_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hw/rtl/grid_bfs_distance_fill_top.sv */
// Top level of the grid distance fill: config register, sequencer and store.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------
//  input    | start, busy              | in_item  (opcode, row, col, cell_open)
//  result   | out_valid (one cycle)    | out_item (distance, reached)
//  config   | psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// Load gives no result and does not raise busy; a read does not raise busy either,
// and its result goes through the store's registered read and then the result register.
// Solve keeps busy high while it clears every cell, then runs one pass per level over
// every cell, with up to four neighbor reads through the single distance read port
// for each open unlabeled cell. Reset clears control state only; the grid
// memories are undefined until written. Results cannot be stalled.
`include "assert_macros.svh"

module grid_bfs_distance_fill_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  gbf_pkg::gbf_in_t     in_item,
  output logic                 out_valid,
  output gbf_pkg::gbf_out_t    out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import gbf_pkg::*;

  logic [SIDE_W-1:0] grid_side_r;
  logic [SIDE_W-1:0] side_use;
  gbf_mem_req_t      mem_req;
  logic              rd_open;
  logic [DIST_W-1:0] rd_dist;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_GRID_SIDE) ? {{(32 - SIDE_W){1'b0}}, grid_side_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_W'(MAX_SIDE);
    end else if (psel && penable && pwrite && pready && (paddr == REG_GRID_SIDE)) begin
      grid_side_r <= pwdata[SIDE_W-1:0];
    end
  end

  // Clamp the side into 1..MAX_SIDE.
  always_comb begin
    if (grid_side_r == '0) begin
      side_use = SIDE_W'(1);
    end else if (grid_side_r > SIDE_W'(MAX_SIDE)) begin
      side_use = SIDE_W'(MAX_SIDE);
    end else begin
      side_use = grid_side_r;
    end
  end

  gbf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .side      (side_use),
    .rd_open   (rd_open),
    .rd_dist   (rd_dist),
    .busy      (busy),
    .mem_req   (mem_req),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  gbf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_open (rd_open),
    .rd_dist (rd_dist)
  );

  `GBF_ASSERT_NXT(a_solve_goes_busy, start && !busy && (in_item.opcode == OP_SOLVE), busy, "solve item did not start the fill")
  `GBF_ASSERT_IMP(a_solve_ends_with_item, $fell(busy), out_valid && out_item.reached, "fill ended without its result item")
  `GBF_ASSERT_IMP(a_unreached_nonzero, out_valid && !out_item.reached, out_item.distance != '0, "unreached cell reported distance zero")

endmodule
